@@ hw/rtl/gng_pkg.sv @@
// Shared types, constants and the generator update function of the noise generator.
`timescale 1ns / 1ps

package gng_pkg;

	localparam int STATE_W = 48;
	localparam int UNIFORM_COUNT_DEF = 12;

	localparam logic [34:0] LCG_MULT = 35'h5_DEEC_E66D;
	localparam logic [47:0] LCG_ADD = 48'hB;
	localparam logic [47:0] SEED_RESET = 48'h1234_ABCD_330E;

	// Register index of the seed in the configuration space.
	localparam logic REG_SEED = 1'b0;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_GEN  = 8'b0000_0010,
		ST_ACC  = 8'b0000_0100,
		ST_CTR  = 8'b0000_1000,
		ST_MLO  = 8'b0001_0000,
		ST_MHI  = 8'b0010_0000,
		ST_FN1  = 8'b0100_0000,
		ST_FN2  = 8'b1000_0000
	} gng_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic accum;
		logic center;
		logic mul_lo;
		logic mul_hi;
		logic fin1;
		logic fin2;
	} gng_cmd_t;

	// One step of the 48-bit congruential generator. Only the low 16 bits of the
	// upper partial product reach the kept 48 bits.
	function automatic logic [47:0] lcg_next(input logic [47:0] s);
		logic [66:0] lo_prod;
		logic [31:0] hi_prod;
		lo_prod = {32'b0, LCG_MULT} * {35'b0, s[31:0]};
		hi_prod = {16'b0, LCG_MULT[15:0]} * {16'b0, s[47:32]};
		return lo_prod[47:0] + {hi_prod[15:0], 32'b0} + LCG_ADD;
	endfunction

endpackage

@@ hw/rtl/gng_ctrl.sv @@
// Sequencing state machine of the noise generator.
`timescale 1ns / 1ps

module gng_ctrl #(
	parameter int UNIFORM_COUNT = gng_pkg::UNIFORM_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output gng_pkg::gng_cmd_t  cmd
);

	localparam int CNT_W = $clog2(UNIFORM_COUNT + 1);

	gng_pkg::gng_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic out_valid_q;
	logic slot_free;

	assign in_stall  = (state_q != gng_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			gng_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = gng_pkg::ST_GEN;
				end
			end
			gng_pkg::ST_GEN: begin
				cmd.step = 1'b1;
				cmd.accum = (count_q != '0);
				if (count_q == CNT_W'(UNIFORM_COUNT - 1)) begin
					state_d = gng_pkg::ST_ACC;
				end
			end
			gng_pkg::ST_ACC: begin
				cmd.accum = 1'b1;
				state_d = gng_pkg::ST_CTR;
			end
			gng_pkg::ST_CTR: begin
				cmd.center = 1'b1;
				state_d = gng_pkg::ST_MLO;
			end
			gng_pkg::ST_MLO: begin
				cmd.mul_lo = 1'b1;
				state_d = gng_pkg::ST_MHI;
			end
			gng_pkg::ST_MHI: begin
				cmd.mul_hi = 1'b1;
				state_d = gng_pkg::ST_FN1;
			end
			gng_pkg::ST_FN1: begin
				cmd.fin1 = 1'b1;
				state_d = gng_pkg::ST_FN2;
			end
			gng_pkg::ST_FN2: begin
				if (slot_free) begin
					cmd.fin2 = 1'b1;
					state_d = gng_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gng_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gng_pkg::ST_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				count_q <= '0;
			end else if (cmd.step) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.fin2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/gng_dp.sv @@
// Datapath of the noise generator: generator state, accumulator, scaling and output register.
`timescale 1ns / 1ps

module gng_dp #(
	parameter int UNIFORM_COUNT = gng_pkg::UNIFORM_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gng_pkg::gng_cmd_t              cmd,
	input  logic                           seed_wr,
	input  logic [gng_pkg::STATE_W-1:0]    seed_data,
	input  logic signed [31:0]             mean_value,
	input  logic [30:0]                    sigma_value,
	output logic signed [31:0]             sample_value,
	output logic                           saturated
);

	localparam int SW   = gng_pkg::STATE_W;
	localparam int ACC_W = SW + $clog2(UNIFORM_COUNT);
	localparam int C_W  = ACC_W + 1;
	localparam int HI_W = C_W - 32;
	localparam int T_W  = C_W + 1;
	localparam int R_W  = C_W - 14;
	localparam logic [C_W-1:0] CENTER = C_W'(UNIFORM_COUNT) << (SW - 1);

	logic [SW-1:0] gen_q;
	logic [ACC_W-1:0] acc_q;
	logic signed [31:0] mean_q;
	logic [30:0] sigma_q;
	logic signed [C_W-1:0] c_q;
	logic [62:0] plo_q;
	logic signed [C_W-1:0] phi_q;
	logic signed [T_W-1:0] t_q;
	logic signed [31:0] sample_q;
	logic sat_q;

	logic signed [C_W-1:0] sig_x, chi_x, phi_d;
	logic signed [R_W-1:0] r_d;
	logic sat_hi, sat_lo;

	always_comb begin
		sig_x = {{(C_W - 31){1'b0}}, sigma_q};
		chi_x = {{32{c_q[C_W-1]}}, c_q[C_W-1:C_W-HI_W]};
		phi_d = sig_x * chi_x;
		// Floor division by 2^16 is the arithmetic shift, taken as a part-select.
		r_d = {{(R_W - 32){mean_q[31]}}, mean_q} + {t_q[T_W-1], t_q[T_W-1:16]};
		sat_hi = !r_d[R_W-1] && (|r_d[R_W-2:31]);
		sat_lo = r_d[R_W-1] && !(&r_d[R_W-2:31]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= gng_pkg::SEED_RESET;
		end else if (seed_wr) begin
			gen_q <= seed_data;
		end else if (cmd.step) begin
			gen_q <= gng_pkg::lcg_next(gen_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mean_q <= mean_value;
			sigma_q <= sigma_value;
			acc_q <= '0;
		end else if (cmd.accum) begin
			acc_q <= acc_q + ACC_W'(gen_q);
		end
		if (cmd.center) begin
			c_q <= $signed({1'b0, acc_q}) - $signed(CENTER);
		end
		if (cmd.mul_lo) begin
			plo_q <= {32'b0, sigma_q} * {31'b0, c_q[31:0]};
		end
		if (cmd.mul_hi) begin
			phi_q <= phi_d;
		end
		if (cmd.fin1) begin
			t_q <= {phi_q[C_W-1], phi_q} + $signed({{(T_W - 31){1'b0}}, plo_q[62:32]});
		end
		if (cmd.fin2) begin
			sat_q <= sat_hi || sat_lo;
			if (sat_hi) begin
				sample_q <= 32'sh7FFF_FFFF;
			end else if (sat_lo) begin
				sample_q <= 32'sh8000_0000;
			end else begin
				sample_q <= r_d[31:0];
			end
		end
	end

	assign sample_value = sample_q;
	assign saturated = sat_q;

endmodule

@@ hw/rtl/gaussian_noise_generator_core.sv @@
// Top level of the Gaussian noise generator: configuration port, controller and datapath.
`timescale 1ns / 1ps

// Each accepted item carries a mean (signed Q16.16) and a standard deviation
// (unsigned Q15.16) and yields one sample of mean plus sigma times the centered
// sum of UNIFORM_COUNT uniform fractions, saturated to the signed 32-bit range
// with the saturated flag raised when clipping occurs. The uniforms come from a
// 48-bit linear congruential generator of the drand48 kind whose state persists
// between items; writing the 48-bit seed register (64-bit data at byte address
// 0) reloads that state, and a read returns the last seed written. The block
// accepts no new item until the current one has reached the result register.
// The run time of an item is set by the generator recurrence: each update is
// one 48-bit multiply-add that depends on the previous one, so one update is
// done per cycle, followed by the accumulate, centering, two partial products
// of the scaling multiply, and rounding, mean addition and saturation. A
// finished sample waits in the output register while the next item is
// already being worked on.
module gaussian_noise_generator_core #(
	parameter int UNIFORM_COUNT = gng_pkg::UNIFORM_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] mean_value,
	input  logic [30:0]        sigma_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] sample_value,
	output logic               saturated,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	gng_pkg::gng_cmd_t cmd;
	logic [gng_pkg::STATE_W-1:0] seed_q;
	logic seed_sel;
	logic seed_wr;

	// The register index is the byte address divided by eight; the seed is the
	// only register, so every other index reads as zero and ignores writes.
	assign pready   = 1'b1;
	assign seed_sel = (paddr[3] == gng_pkg::REG_SEED);
	assign seed_wr  = psel && penable && pwrite && pready && seed_sel;
	assign prdata   = seed_sel ? {16'b0, seed_q} : 64'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= gng_pkg::SEED_RESET;
		end else if (seed_wr) begin
			seed_q <= pwdata[gng_pkg::STATE_W-1:0];
		end
	end

	// The controller walks each item through its steps and owns both handshakes.
	gng_ctrl #(
		.UNIFORM_COUNT(UNIFORM_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	// The datapath holds the generator state and does all arithmetic on command.
	gng_dp #(
		.UNIFORM_COUNT(UNIFORM_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.seed_wr     (seed_wr),
		.seed_data   (pwdata[gng_pkg::STATE_W-1:0]),
		.mean_value  (mean_value),
		.sigma_value (sigma_value),
		.sample_value(sample_value),
		.saturated   (saturated)
	);

endmodule

@@ tb/tb_gaussian_noise_generator_core.sv @@
// Self-checking testbench of the Gaussian noise generator core.
`timescale 1ns / 1ps

module tb_gaussian_noise_generator_core;

	// Generator constants of the drand48 recurrence and the sum of uniforms.
	localparam int UNIFORMS = 12;
	localparam logic [34:0] DRAND_MULT = 35'h5_DEEC_E66D;
	localparam logic [47:0] DRAND_INC = 48'hB;
	localparam logic [47:0] DEFAULT_SEED = 48'h1234_ABCD_330E;
	localparam longint CENTER_OFFSET = longint'(UNIFORMS) << 47;

	// The seed is register zero; registers sit at 8-byte strides.
	localparam logic SEED_REG_INDEX = 1'b0;
	localparam logic [3:0] SEED_ADDR = 4'h0;
	localparam logic [3:0] UNMAPPED_ADDR = 4'h8;

	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               sat;
	} noise_result_t;

	// One row of the directed table. Rows with known set carry a result that is
	// obvious by inspection; the others are checked against the predictor.
	typedef struct packed {
		logic signed [31:0] mean;
		logic [30:0]        sigma;
		logic               known;
		logic signed [31:0] want_sample;
		logic               want_sat;
	} directed_row_t;

	localparam int DIRECTED_COUNT = 20;
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// A zero sigma returns the mean exactly, whatever the uniforms are.
		'{32'sh0000_0000, 31'h0000_0000, 1'b1, 32'sh0000_0000, 1'b0},
		'{32'sh7FFF_FFFF, 31'h0000_0000, 1'b1, 32'sh7FFF_FFFF, 1'b0},
		'{32'sh8000_0000, 31'h0000_0000, 1'b1, 32'sh8000_0000, 1'b0},
		'{32'shFFFF_FFFF, 31'h0000_0000, 1'b1, 32'shFFFF_FFFF, 1'b0},
		'{32'sh0001_0000, 31'h0000_0000, 1'b1, 32'sh0001_0000, 1'b0},
		// The smallest sigma exercises floor rounding of negative products.
		'{32'sh0000_0000, 31'h0000_0001, 1'b0, 32'sh0, 1'b0},
		'{32'sh0000_0000, 31'h0000_0001, 1'b0, 32'sh0, 1'b0},
		'{32'sh0000_0000, 31'h0001_0000, 1'b0, 32'sh0, 1'b0},
		'{32'sh0000_0000, 31'h7FFF_FFFF, 1'b0, 32'sh0, 1'b0},
		// Extreme means with the largest sigma drive both saturation limits.
		'{32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 32'sh0, 1'b0},
		'{32'sh8000_0000, 31'h7FFF_FFFF, 1'b0, 32'sh0, 1'b0},
		'{32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 32'sh0, 1'b0},
		'{32'sh8000_0000, 31'h7FFF_FFFF, 1'b0, 32'sh0, 1'b0},
		'{32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 32'sh0, 1'b0},
		'{32'sh8000_0000, 31'h7FFF_FFFF, 1'b0, 32'sh0, 1'b0},
		'{32'sh5555_5555, 31'h2AAA_AAAA, 1'b0, 32'sh0, 1'b0},
		'{32'shAAAA_AAAA, 31'h5555_5555, 1'b0, 32'sh0, 1'b0},
		'{32'shFFFF_0000, 31'h0000_0001, 1'b0, 32'sh0, 1'b0},
		'{32'sh1234_5678, 31'h0000_8000, 1'b0, 32'sh0, 1'b0},
		'{32'sh7FFF_0000, 31'h4000_0000, 1'b0, 32'sh0, 1'b0}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] mean_value;
	logic [30:0]        sigma_value;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] sample_value;
	logic               saturated;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [63:0]        pwdata;
	logic [63:0]        prdata;
	logic               pready;

	gaussian_noise_generator_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mean_value  (mean_value),
		.sigma_value (sigma_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_value(sample_value),
		.saturated   (saturated),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// Predictor copy of the seed register and of the generator state.
	logic [47:0] seed_copy;
	logic [47:0] drand_state;

	noise_result_t pending_samples [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit idling_on = 1'b1;
	bit long_hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Steps the generator twelve times and forms mean + sigma * centered sum,
	// rounded toward minus infinity and clipped to the signed 32-bit range.
	function automatic noise_result_t predict_sample(input logic signed [31:0] mean,
			input logic [30:0] sigma);
		logic [95:0] prod;
		logic [52:0] uniform_sum;
		logic signed [63:0] centered;
		logic signed [127:0] scaled;
		logic signed [63:0] total;
		noise_result_t res;
		int k;
		uniform_sum = '0;
		for (k = 0; k < UNIFORMS; k++) begin
			prod = {61'b0, DRAND_MULT} * {48'b0, drand_state};
			drand_state = prod[47:0] + DRAND_INC;
			uniform_sum = uniform_sum + {5'b0, drand_state};
		end
		centered = $signed({11'b0, uniform_sum}) - CENTER_OFFSET;
		scaled = $signed({97'b0, sigma}) * $signed({{64{centered[63]}}, centered});
		// The arithmetic shift floors; the product never needs more than 111 bits.
		total = scaled[111:48];
		total = total + {{32{mean[31]}}, mean};
		res.sat = 1'b0;
		if (total > 64'sd2147483647) begin
			total = 64'sd2147483647;
			res.sat = 1'b1;
		end else if (total < -64'sd2147483648) begin
			total = -64'sd2147483648;
			res.sat = 1'b1;
		end
		res.sample = total[31:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH (cycle %0d): %s", cycle_count, what);
		mismatch_count++;
	endtask

	// A register write with a setup and an access phase, after which the bus
	// goes idle. Only register zero exists; any other index is ignored by the
	// block, and the seed keeps its low 48 bits.
	task automatic seed_write(input logic [3:0] addr, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[3] == SEED_REG_INDEX) begin
			seed_copy = data[47:0];
			drand_state = seed_copy;
		end
		@(posedge clk);
	endtask

	// Waits until every predicted sample has come out, then lets the pipeline
	// settle before the next register write.
	task automatic wait_drained();
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offers one item and holds it until accepted. The predictor advances on
	// acceptance; a typed result, where given, replaces its answer.
	task automatic send_request(input logic signed [31:0] m, input logic [30:0] s,
			input logic use_typed, input noise_result_t typed_res, input logic last_one);
		noise_result_t predicted;
		in_valid <= 1'b1;
		mean_value <= m;
		sigma_value <= s;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		predicted = predict_sample(m, s);
		pending_samples.push_back(use_typed ? typed_res : predicted);
		if (last_one) begin
			in_valid <= 1'b0;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Random requests: full-range fields most often, with some small sigmas, zero
	// and full sigmas, and means near the limits to reach both saturations.
	task automatic random_requests(input int count);
		logic signed [31:0] m;
		logic [30:0] s;
		int i;
		int pick;
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			m = $urandom;
			s = 31'($urandom);
			if (pick < 40) begin
				// Full range on both fields.
			end else if (pick < 65) begin
				s = 31'($urandom_range(0, 32'h0003_FFFF));
			end else if (pick < 85) begin
				m = {($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h8000, 16'($urandom)};
				s = s | 31'h4000_0000;
			end else if (pick < 95) begin
				s = '0;
			end else begin
				s = 31'h7FFF_FFFF;
			end
			send_request(m, s, 1'b0, '0, i == count - 1);
		end
	endtask

	// Cycle counter and run limit.
	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles, %0d samples outstanding", cycle_count,
					pending_samples.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold that lets the block fill
	// up and stall its input.
	initial begin : receiver
		int burst;
		burst = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				burst = $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Every sample accepted by the receiver is compared with the oldest prediction.
	initial begin : checker_proc
		noise_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_samples.size() == 0) begin
					report_mismatch($sformatf("unexpected sample %h sat %b",
						sample_value, saturated));
				end else begin
					want = pending_samples.pop_front();
					if (sample_value !== want.sample)
						report_mismatch($sformatf("sample_value %h, predicted %h",
							sample_value, want.sample));
					if (saturated !== want.sat)
						report_mismatch($sformatf("saturated %b, predicted %b (sample %h)",
							saturated, want.sat, want.sample));
				end
			end
		end
	end

	initial begin : stimulus
		int n;
		directed_row_t row;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mean_value <= '0;
		sigma_value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		seed_copy = DEFAULT_SEED;
		drand_state = DEFAULT_SEED;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run from the reset seed.
		for (n = 0; n < DIRECTED_COUNT; n++) begin
			row = DIRECTED_ROWS[n];
			send_request(row.mean, row.sigma, row.known, {row.want_sample, row.want_sat},
				n == DIRECTED_COUNT - 1);
		end

		// All-zero seed.
		wait_drained();
		seed_write(SEED_ADDR, 64'h0);
		random_requests(200);

		// All-ones seed, with the long receiver hold while items keep coming.
		wait_drained();
		seed_write(SEED_ADDR, 64'h0000_FFFF_FFFF_FFFF);
		long_hold_req = 1'b1;
		random_requests(150);

		// Bits above the seed width must be dropped, and a write to an unmapped
		// register must leave the generator alone.
		wait_drained();
		seed_write(SEED_ADDR, {16'($urandom) | 16'h8001, 16'($urandom), 32'($urandom)});
		seed_write(UNMAPPED_ADDR, {32'($urandom), 32'($urandom)});
		random_requests(150);

		wait_drained();
		seed_write(SEED_ADDR, {32'($urandom), 32'($urandom)});
		random_requests(150);

		// Last stretch back on the default seed, with no idling on either side.
		wait_drained();
		idling_on = 1'b0;
		seed_write(SEED_ADDR, {16'h0, DEFAULT_SEED});
		random_requests(200);

		wait_drained();
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/gng_pkg.sv
hw/rtl/gng_ctrl.sv
hw/rtl/gng_dp.sv
hw/rtl/gaussian_noise_generator_core.sv
tb/tb_gaussian_noise_generator_core.sv
